// ----- rtl/smpq_pkg.sv -----
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and codes for the sorted max-priority queue
// Operation and status codes, fixed port widths and the cell control struct.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int KEY_IO_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

// ----- rtl/smpq_cell.sv -----
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted key row
// Holds one key; on insert keeps, takes the new key or takes the key of the
// neighbor above; on remove takes the key of the neighbor below.
// ----------------------------------------------------------------------------
module smpq_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                        i_clk,
    input  smpq_pkg::t_cell_ctrl        i_ctrl,
    input  logic signed [KEY_WIDTH-1:0] i_new_key,
    input  logic                        i_occupied,
    input  logic                        i_prev_ge,
    input  logic signed [KEY_WIDTH-1:0] i_prev_key,
    input  logic signed [KEY_WIDTH-1:0] i_next_key,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic                        o_ge
);
    import smpq_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] n_key;

    // Occupied and not smaller than the incoming key: this slot stays put.
    assign o_ge = i_occupied && (r_key >= i_new_key);

    always_comb begin
        n_key = r_key;
        if (i_ctrl.insert) begin
            if (o_ge) begin
                n_key = r_key;
            end else if (i_prev_ge) begin
                n_key = i_new_key;
            end else begin
                n_key = i_prev_key;
            end
        end else if (i_ctrl.remove) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// ----- rtl/sorted_max_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_unit: max-priority queue on a row of key cells
// Insert a signed key or remove the largest; one result beat per item.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY signed keys in a row of cells sorted in
// descending order, the maximum always in cell 0. Every item is one beat:
// func selects insert (key_in) or remove-maximum. An insert compares the key
// against all cells at once and shifts every smaller key down one cell; a
// remove returns cell 0 and shifts the row up. Both finish in the clock in
// which the item is accepted, so the block takes one item per cycle unless
// the output stalls and shows its result in the next cycle; the rate is set
// by the compare-and-shift of the cell row. The output stage is one register:
// a new item is taken while the pending result is being taken in the same
// cycle. Remove on empty returns status 1, insert on full returns status 2;
// neither changes the queue, and key_out is zero for both. occupancy is the
// key count after the item, truncated to 7 bits.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_unit #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_func,
    input  logic signed [smpq_pkg::KEY_IO_W-1:0]  i_key_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [smpq_pkg::KEY_IO_W-1:0]  o_key_out,
    output logic        [smpq_pkg::STATUS_W-1:0]  o_status,
    output logic        [smpq_pkg::OCC_W-1:0]     o_occupancy
);
    import smpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                        accept;
    logic                        is_full;
    logic                        is_empty;
    t_cell_ctrl                  ctrl;
    logic signed [KEY_WIDTH-1:0] new_key;
    logic signed [KEY_IO_W-1:0]  top_key_io;

    logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic                        cell_ge  [CAPACITY];

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic signed [KEY_IO_W-1:0]  r_key_out;
    logic [STATUS_W-1:0]         r_status;
    logic [STATUS_W-1:0]         n_status;
    logic signed [KEY_IO_W-1:0]  n_key_out;
    logic [CW+OCC_W-1:0]         occ_wide;
    logic [OCC_W-1:0]            r_occupancy;

    // Take a new item whenever the output register is free or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);

    // Fit the 32-bit port key to the stored width and back.
    generate
        if (KEY_WIDTH <= KEY_IO_W) begin : g_key_narrow
            assign new_key    = i_key_in[KEY_WIDTH-1:0];
            // Sign-extend the stored key to the port width.
            assign top_key_io = KEY_IO_W'(cell_key[0]);
        end else begin : g_key_wide
            assign new_key    = {{(KEY_WIDTH-KEY_IO_W){i_key_in[KEY_IO_W-1]}}, i_key_in};
            assign top_key_io = cell_key[0][KEY_IO_W-1:0];
        end
    endgenerate

    // Broadcast the command; an insert on full or remove on empty is a no-op.
    always_comb begin
        ctrl.insert = accept && (i_func == FUNC_INSERT) && !is_full;
        ctrl.remove = accept && (i_func == FUNC_REMOVE) && !is_empty;
    end

    // Row of cells, cell 0 holds the maximum.
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic                        prev_ge;
            logic signed [KEY_WIDTH-1:0] prev_key;
            logic signed [KEY_WIDTH-1:0] next_key;

            if (g == 0) begin : g_head
                assign prev_ge  = 1'b1;
                assign prev_key = new_key;
            end else begin : g_body
                assign prev_ge  = cell_ge[g-1];
                assign prev_key = cell_key[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign next_key = cell_key[g];
            end else begin : g_inner
                assign next_key = cell_key[g+1];
            end

            smpq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_new_key  (new_key),
                .i_occupied (r_count > CW'(g)),
                .i_prev_ge  (prev_ge),
                .i_prev_key (prev_key),
                .i_next_key (next_key),
                .o_key      (cell_key[g]),
                .o_ge       (cell_ge[g])
            );
        end
    endgenerate

    // Next count, status and returned key for the accepted beat.
    always_comb begin
        n_count   = r_count;
        n_status  = STATUS_OK;
        n_key_out = '0;
        if (i_func == FUNC_INSERT) begin
            if (is_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_count   = r_count - CW'(1);
                n_key_out = top_key_io;
            end
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                // Drop the result once it has been taken.
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_out   <= n_key_out;
            r_status    <= n_status;
            r_occupancy <= occ_wide[OCC_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_key_out;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;

endmodule

// ----- rtl/smpq_checker.sv -----
// ----------------------------------------------------------------------------
// smpq_checker: port-level checks for the sorted max-priority queue
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module smpq_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [smpq_pkg::KEY_IO_W-1:0]  o_key_out,
    input  logic        [smpq_pkg::STATUS_W-1:0]  o_status,
    input  logic        [smpq_pkg::OCC_W-1:0]     o_occupancy
);
    import smpq_pkg::*;

    localparam int OCC_FULL_I = CAPACITY % (1 << OCC_W);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_FULL_I[OCC_W-1:0];

    // A failed remove returns no key and reports an empty queue.
    a_empty_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_EMPTY) |-> (o_key_out == '0 && o_occupancy == '0))
        else $error("remove on empty reported a key or nonzero occupancy");

    // A rejected insert leaves the queue at capacity.
    a_full_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_FULL) |-> (o_key_out == '0 && o_occupancy == OCC_FULL))
        else $error("insert on full reported wrong key or occupancy");

    // Status never takes the unused code.
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK || o_status == STATUS_EMPTY ||
                         o_status == STATUS_FULL))
        else $error("undefined status code");

    // A stalled result beat holds.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_key_out) && $stable(o_status) && $stable(o_occupancy)))
        else $error("result beat changed while stalled");

endmodule

bind sorted_max_priority_queue_unit smpq_checker #(
    .CAPACITY (CAPACITY)
) u_smpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_key_out   (o_key_out),
    .o_status    (o_status),
    .o_occupancy (o_occupancy)
);
